/* sv/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and types of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int FREE_DEPTH   = 256;
  localparam int PTR_W        = $clog2(FREE_DEPTH);
  localparam int FILL_W       = PTR_W + 1;
  localparam int REGION_COUNT = 3;
  localparam int ADDR_W       = 52;
  localparam int PAGE_SHIFT   = 12;
  localparam int FRAME_W      = ADDR_W - PAGE_SHIFT;
  // Frame number of a region's next page: rounded-up start plus pages taken.
  localparam int NF_W         = FRAME_W + 2;
  localparam int CFG_COUNT    = 2 * REGION_COUNT;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_ADDR_W   = CFG_IDX_W + 3;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOM  = 2'd1,
    STAT_FULL = 2'd2
  } pfa_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } pfa_state_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

/* sv/page_frame_allocator.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator
// Hands out and takes back 4 KiB page frames from a free FIFO and up to three
// bump-allocated regions.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. in_action
// low asks for a frame, high returns in_freed_frame to the free FIFO. Every
// request gives exactly one word on out_status / out_given_frame, marked by a
// one-cycle out_valid strobe; the receiver cannot stall, so it must take the
// word in that cycle.
// out_valid is registered from the done state, and busy drops in that same
// cycle, so a new request can be taken while the result word is shown.
// The free FIFO RAM read is registered at the accepting edge; the region pass
// adds the rounded start to the pages taken in the calc state, then compares
// against the region end and picks a region in the done state.
// Freed frames are returned oldest first; when the FIFO is empty regions 0, 1
// and 2 are tried in order. A free into a full FIFO reports status 2.
// Region start/end registers sit on the APB port at byte addresses 8*i and
// should be written only while the block is idle. Reset empties the FIFO,
// clears every region's page count and clears all region registers.
// ----------------------------------------------------------------------------
module page_frame_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_action,
  input  logic [pfa_pkg::FRAME_W-1:0]     in_freed_frame,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [pfa_pkg::FRAME_W-1:0]     out_given_frame,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pfa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import pfa_pkg::*;

  pfa_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FRAME_W-1:0]  pages_r [REGION_COUNT];
  logic [FRAME_W-1:0]  pages_nxt [REGION_COUNT];
  logic [ADDR_W-1:0]   cfg_r [CFG_COUNT];
  logic [NF_W-1:0]     nf_r [REGION_COUNT];
  logic [REGION_COUNT-1:0] fit;
  logic                act_r;
  logic                out_valid_r, out_valid_nxt;
  pfa_status_t         out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]  out_given_r, out_given_nxt;
  logic                found;
  logic                accept;
  logic                full;
  logic                cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [FRAME_W-1:0]  ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (fill_r == FILL_W'(FREE_DEPTH));

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_we  = psel && penable && pwrite && (32'(cfg_idx) < CFG_COUNT);

  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < CFG_COUNT) begin
      prdata = CFG_DATA_W'(cfg_r[cfg_idx]);
    end
  end

  pfa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (FREE_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (accept && (in_action == ACT_FREE) && !full),
    .waddr (wr_ptr_r),
    .wdata (in_freed_frame),
    .re    (accept && (in_action == ACT_ALLOC)),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // A region has room when its start is nonzero and its next frame lies wholly
  // below the end address, which in frame units is next < end >> 12.
  always_comb begin
    for (int r = 0; r < REGION_COUNT; r++) begin
      fit[r] = (cfg_r[2*r] != '0) &&
               (nf_r[r] < NF_W'(cfg_r[2*r+1][ADDR_W-1:PAGE_SHIFT]));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    pages_nxt      = pages_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_given_nxt  = out_given_r;
    found          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt      = ST_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_given_nxt  = '0;
        if (act_r == ACT_FREE) begin
          if (full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
            fill_nxt   = fill_r + FILL_W'(1);
          end
        end else if (fill_r != '0) begin
          out_given_nxt = ram_rdata;
          rd_ptr_nxt    = rd_ptr_r + PTR_W'(1);
          fill_nxt      = fill_r - FILL_W'(1);
        end else begin
          for (int r = 0; r < REGION_COUNT; r++) begin
            if (!found && fit[r]) begin
              found         = 1'b1;
              out_given_nxt = nf_r[r][FRAME_W-1:0];
              pages_nxt[r]  = pages_r[r] + FRAME_W'(1);
            end
          end
          if (!found) begin
            out_status_nxt = STAT_OOM;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < REGION_COUNT; r++) begin
        pages_r[r] <= '0;
      end
      for (int i = 0; i < CFG_COUNT; i++) begin
        cfg_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pages_r     <= pages_nxt;
      if (cfg_we) begin
        cfg_r[cfg_idx] <= pwdata[ADDR_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
    end
    // Next frame per region: start rounded up to a page plus pages taken.
    if (state_r == ST_CALC) begin
      for (int r = 0; r < REGION_COUNT; r++) begin
        nf_r[r] <= NF_W'(cfg_r[2*r][ADDR_W-1:PAGE_SHIFT])
                 + NF_W'(|cfg_r[2*r][PAGE_SHIFT-1:0])
                 + NF_W'(pages_r[r]);
      end
    end
    out_status_r <= out_status_nxt;
    out_given_r  <= out_given_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_given_frame = out_given_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FREE_DEPTH))
    else $error("free FIFO fill count above depth");

  a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[PTR_W-1:0] == PTR_W'(wr_ptr_r - rd_ptr_r))
    else $error("free FIFO fill count disagrees with pointers");

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_DONE))
    else $error("result strobe without a finished request");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CALC) ##1 (state_r == ST_DONE) ##1 out_valid_r)
    else $error("accepted request did not produce a result");

endmodule

/* sv/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page frame allocator. Requests go in through the
// start/busy port and the bench keeps its own model of the free FIFO and of
// the three bump regions, so every result word is checked against the
// expected status and frame. Region registers are reprogrammed over the APB
// port between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import pfa_pkg::*;

  typedef enum int {
    REG_R0_START = 0,
    REG_R0_END   = 1,
    REG_R1_START = 2,
    REG_R1_END   = 3,
    REG_R2_START = 4,
    REG_R2_END   = 5
  } region_reg_t;

  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] frame;
  } frame_request_t;

  typedef struct packed {
    pfa_status_t        status;
    logic [FRAME_W-1:0] frame;
  } frame_reply_t;

  typedef logic bool_found_t;

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;
  localparam logic [63:0] PAGE_SIZE = 64'd1 << PAGE_SHIFT;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_action = ACT_ALLOC;
  logic [FRAME_W-1:0]    in_freed_frame = '0;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [FRAME_W-1:0]    out_given_frame;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  page_frame_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_freed_frame(in_freed_frame),
    .out_valid(out_valid), .out_status(out_status), .out_given_frame(out_given_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  frame_request_t requests_todo[$];
  frame_reply_t   replies_due[$];
  int             gap_pct = 0;
  int             gap_left = 0;
  int             errors = 0;

  // Allocator state as the bench sees it.
  logic [FRAME_W-1:0] free_fifo[FREE_DEPTH];
  int                 fifo_rd = 0;
  int                 fifo_wr = 0;
  int                 fifo_count = 0;
  logic [FRAME_W-1:0] pages_used[REGION_COUNT] = '{default: '0};
  logic [ADDR_W-1:0]  region_lo[REGION_COUNT] = '{default: '0};
  logic [ADDR_W-1:0]  region_hi[REGION_COUNT] = '{default: '0};

  function automatic logic [63:0] page_round_up(input logic [63:0] addr);
    if (addr[PAGE_SHIFT-1:0] != '0) begin
      return (addr | (PAGE_SIZE - 64'd1)) + 64'd1;
    end
    return addr;
  endfunction

  task automatic serve_request(input logic action, input logic [FRAME_W-1:0] frame,
                               output frame_reply_t reply);
    logic [63:0] next_addr;
    bool_found_t found;
    reply = '{STAT_OK, '0};
    if (action == ACT_FREE) begin
      if (fifo_count >= FREE_DEPTH) begin
        reply.status = STAT_FULL;
      end else begin
        free_fifo[fifo_wr] = frame;
        fifo_wr = (fifo_wr + 1) % FREE_DEPTH;
        fifo_count++;
      end
    end else if (fifo_count > 0) begin
      reply.frame = free_fifo[fifo_rd];
      fifo_rd = (fifo_rd + 1) % FREE_DEPTH;
      fifo_count--;
    end else begin
      found = 1'b0;
      for (int r = 0; r < REGION_COUNT; r++) begin
        if (!found && region_lo[r] != '0) begin
          next_addr = page_round_up({12'b0, region_lo[r]}) +
                      ({24'b0, pages_used[r]} << PAGE_SHIFT);
          if (next_addr + PAGE_SIZE <= {12'b0, region_hi[r]}) begin
            reply.frame = next_addr[ADDR_W-1:PAGE_SHIFT];
            pages_used[r] = pages_used[r] + FRAME_W'(1);
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        reply.status = STAT_OOM;
      end
    end
  endtask

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Driver: holds start until the word is taken, with random idle bursts.
  always @(posedge clk) begin : drive
    frame_request_t rq;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (requests_todo.size() != 0) begin
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
          gap_left <= $urandom_range(0, 6);
          start <= 1'b0;
        end else begin
          rq = requests_todo.pop_front();
          in_action <= rq.action;
          in_freed_frame <= rq.frame;
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result word, then predicts for a newly taken request.
  always @(posedge clk) begin : watch
    frame_reply_t want;
    frame_reply_t due;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        note_error($sformatf("unexpected result word: status %0d frame 0x%h",
                             out_status, out_given_frame));
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status || out_given_frame !== want.frame) begin
          note_error($sformatf({"result mismatch: expected status %0d frame 0x%h, ",
                                "got status %0d frame 0x%h"},
                               want.status, want.frame, out_status, out_given_frame));
        end
      end
    end
    if (rst_n && start && !busy) begin
      serve_request(in_action, in_freed_frame, due);
      replies_due.push_back(due);
    end
  end

  task automatic queue_req(input logic action, input logic [FRAME_W-1:0] frame);
    requests_todo.push_back('{action, frame});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (requests_todo.size() != 0 || start || replies_due.size() != 0);
  endtask

  // APB write; the model's copy of the register follows the block's.
  task automatic cfg_write(input int idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < CFG_COUNT) begin
      if (idx % 2 == 0) region_lo[idx / 2] = value[ADDR_W-1:0];
      else region_hi[idx / 2] = value[ADDR_W-1:0];
    end
  endtask

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom} & ADDR_MASK;
  endfunction

  // Picks a region: unused, with its end below its start, or sized around the
  // pages already handed out, so that it gives a few frames before running dry.
  task automatic pick_region(input int r);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    logic [11:0] junk;
    span = ({24'b0, pages_used[r]} + 64'($urandom_range(0, 12))) << PAGE_SHIFT;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        lo = 64'd0;
        hi = rand_addr();
      end
      3, 4, 5: begin
        lo = rand_addr() | (64'd1 << 44);
        hi = lo - 64'($urandom_range(1, 16384));
      end
      6, 7, 8, 9: begin
        hi = ADDR_MASK;
        lo = hi - span - 64'($urandom_range(0, 4095));
      end
      default: begin
        lo = rand_addr();
        hi = page_round_up(lo) + span + 64'($urandom_range(0, 8191));
      end
    endcase
    junk = 12'($urandom);
    cfg_write(2 * r, {junk, lo[51:0]});
    junk = 12'($urandom);
    cfg_write(2 * r + 1, {junk, hi[51:0]});
  endtask

  initial begin
    int alloc_pct;
    int n_items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // No regions yet: allocation only works from freed frames.
    gap_pct = 30;
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_FREE, '0);
    queue_req(ACT_FREE, '1);
    queue_req(ACT_FREE, 40'h55_5555_5555);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    wait_drained();

    // Unaligned start with an exact two-page fit, a region at the top of the
    // address space, and a region whose end lies below its start. Upper bits
    // of the write data must be dropped.
    cfg_write(REG_R0_START, 64'hFFF0_0000_0000_1001);
    cfg_write(REG_R0_END, 64'h4000);
    cfg_write(REG_R1_START, 64'h000F_FFFF_FFFF_E000);
    cfg_write(REG_R1_END, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_R2_START, 64'h90_0000);
    cfg_write(REG_R2_END, 64'h80_0000);
    cfg_write(CFG_COUNT, '1);
    cfg_write(CFG_COUNT + 1, '1);
    repeat (4) queue_req(ACT_ALLOC, '0);
    queue_req(ACT_FREE, 40'h12345);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    wait_drained();

    // Unused region 0, a start that rounds past its end, a one-page region.
    cfg_write(REG_R0_START, 64'h0);
    cfg_write(REG_R0_END, ADDR_MASK);
    cfg_write(REG_R1_START, ADDR_MASK);
    cfg_write(REG_R1_END, ADDR_MASK);
    cfg_write(REG_R2_START, 64'h1000);
    cfg_write(REG_R2_END, 64'h2000);
    queue_req(ACT_ALLOC, '0);
    queue_req(ACT_ALLOC, '0);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < REGION_COUNT; r++) begin
        pick_region(r);
      end
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(CFG_COUNT + $urandom_range(0, 1), {$urandom, $urandom});
      end
      gap_pct = (ph >= 8 || ph == 5) ? 0 : $urandom_range(10, 50);
      if (ph == 3) begin
        // Overrun the free FIFO, then drain it and keep going into the regions.
        for (int i = 0; i < 262; i++) begin
          queue_req(ACT_FREE, FRAME_W'({$urandom, $urandom}));
        end
        for (int i = 0; i < 268; i++) begin
          queue_req(ACT_ALLOC, '0);
        end
      end else begin
        alloc_pct = $urandom_range(50, 80);
        n_items = 130;
        for (int i = 0; i < n_items; i++) begin
          if ($urandom_range(99) < alloc_pct) begin
            queue_req(ACT_ALLOC, FRAME_W'({$urandom, $urandom}));
          end else if ($urandom_range(0, 1) == 0) begin
            queue_req(ACT_FREE, FRAME_W'({$urandom, $urandom}));
          end else begin
            queue_req(ACT_FREE, FRAME_W'($urandom_range(0, 4095)));
          end
        end
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/pfa_pkg.sv
sv/pfa_ram.sv
sv/page_frame_allocator.sv
tb/tb_top.sv
